// File: design/market_feed_price_table_macros.svh
// ----------------------------------------------------------------------------
// market feed price table assertion macros
// concurrent assertion shorthands shared by the price table rtl
// ----------------------------------------------------------------------------
`ifndef MARKET_FEED_PRICE_TABLE_MACROS_SVH
`define MARKET_FEED_PRICE_TABLE_MACROS_SVH

// same-cycle implication, disabled in reset
`define MPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled in reset
`define MPT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: design/mpt_pkg.sv
// ----------------------------------------------------------------------------
// mpt_pkg
// shared codes, result types and the fnv-1a byte step of the price table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mpt_pkg;

  localparam logic [1:0] OP_APPLY    = 2'd0;
  localparam logic [1:0] OP_QUERY    = 2'd1;
  localparam logic [1:0] OP_CHECKSUM = 2'd2;
  localparam logic [1:0] OP_COUNTER  = 2'd3;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_GAP       = 4'd1;
  localparam logic [3:0] ST_DUP       = 4'd2;
  localparam logic [3:0] ST_STALE     = 4'd3;
  localparam logic [3:0] ST_BAD_EXCH  = 4'd4;
  localparam logic [3:0] ST_BAD_INSTR = 4'd5;
  localparam logic [3:0] ST_BAD_PRICE = 4'd6;
  localparam logic [3:0] ST_BAD_SEQ   = 4'd7;
  localparam logic [3:0] ST_PRICE_ROW = 4'd8;
  localparam logic [3:0] ST_MISSING   = 4'd9;
  localparam logic [3:0] ST_NO_INSTR  = 4'd10;
  localparam logic [3:0] ST_VALUE     = 4'd11;

  localparam logic [2:0] CNT_RECEIVED  = 3'd0;
  localparam logic [2:0] CNT_INVALID   = 3'd1;
  localparam logic [2:0] CNT_DUPLICATE = 3'd2;
  localparam logic [2:0] CNT_STALE     = 3'd3;
  localparam logic [2:0] CNT_ACCEPTED  = 3'd4;
  localparam logic [2:0] CNT_GAP_EVENT = 3'd5;
  localparam logic [2:0] CNT_MISSING   = 3'd6;
  localparam logic [2:0] CNT_NONE      = 3'd7;
  localparam int         NUM_COUNTERS  = 7;

  localparam logic [0:0] CFG_EXCHANGES   = 1'b0;
  localparam logic [0:0] CFG_INSTRUMENTS = 1'b1;

  localparam logic [63:0] FNV_BASIS = 64'd14695981039346656037;

  typedef struct packed {
    logic        init;
    logic        start;
    logic [63:0] word;
  } fnv_req_t;

  typedef struct packed {
    logic [3:0]         status;
    logic [63:0]        gap_count;
    logic [3:0]         exchange_out;
    logic signed [63:0] price_out;
    logic [63:0]        sequence_out;
    logic [63:0]        timestamp_out;
    logic [63:0]        value_out;
    logic               last;
  } res_t;

  // xor in one byte, then multiply by the prime 2^40 + 0x1b3 as shifts
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

// File: design/mpt_if.sv
// ----------------------------------------------------------------------------
// mpt channel interfaces
// valid/ready channels for update and query items and for result items
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mpt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [15:0]        exchange_num;
  logic [31:0]        instrument_num;
  logic signed [63:0] price_in;
  logic [63:0]        sequence_in;
  logic [63:0]        timestamp_in;
  logic [2:0]         counter_select;

  modport source (output valid, op, exchange_num, instrument_num, price_in,
                  sequence_in, timestamp_in, counter_select, input ready);
  modport sink (input valid, op, exchange_num, instrument_num, price_in,
                sequence_in, timestamp_in, counter_select, output ready);
endinterface

interface mpt_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         status;
  logic [63:0]        gap_count;
  logic [3:0]         exchange_out;
  logic signed [63:0] price_out;
  logic [63:0]        sequence_out;
  logic [63:0]        timestamp_out;
  logic [63:0]        value_out;
  logic               last;

  modport source (output valid, status, gap_count, exchange_out, price_out,
                  sequence_out, timestamp_out, value_out, last, input ready);
  modport sink (input valid, status, gap_count, exchange_out, price_out,
                sequence_out, timestamp_out, value_out, last, output ready);
endinterface

// File: design/market_feed_price_table.sv
// ----------------------------------------------------------------------------
// market_feed_price_table
// price table per instrument and exchange with sequence checks and queries
// ----------------------------------------------------------------------------
// After reset the block sweeps the valid marks of the table, one entry per
// cycle, and takes no item meanwhile; configuration writes are taken at any
// time. Items are handled one at a time on the single table port. An update
// that a field check rejects skips the table read and the sequence check.
// In a query each sorted row is one scan of the instrument's entries, a read
// and a compare per entry. A checksum hashes 64-bit words one byte per cycle
// through the fnv unit: 2 + E words for E exchanges, then for each of the
// E*I entries of I instruments one word plus three more when it is valid.
`timescale 1ns / 1ps

module market_feed_price_table #(
  parameter int MAX_EXCHANGES   = 16,
  parameter int MAX_INSTRUMENTS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  mpt_in_if.sink      in_ch,
  mpt_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  import mpt_pkg::*;
`include "market_feed_price_table_macros.svh"

  localparam int TABLE    = MAX_EXCHANGES * MAX_INSTRUMENTS;
  localparam int IDX_W    = (TABLE > 1) ? $clog2(TABLE) : 1;
  localparam int EW       = $clog2(MAX_EXCHANGES + 1);
  localparam int IW       = $clog2(MAX_INSTRUMENTS + 1);
  localparam int XW       = (MAX_EXCHANGES > 1) ? $clog2(MAX_EXCHANGES) : 1;
  localparam int PW       = IW + EW;
  localparam int KW       = 63 + EW;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE - 1);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_A1   = 4'd2;
  localparam logic [3:0] S_A2   = 4'd3;
  localparam logic [3:0] S_A3   = 4'd4;
  localparam logic [3:0] S_Q0   = 4'd5;
  localparam logic [3:0] S_QPS  = 4'd6;
  localparam logic [3:0] S_QRD  = 4'd7;
  localparam logic [3:0] S_QCMP = 4'd8;
  localparam logic [3:0] S_QEND = 4'd9;
  localparam logic [3:0] S_MRD  = 4'd10;
  localparam logic [3:0] S_MCHK = 4'd11;
  localparam logic [3:0] S_C0   = 4'd12;
  localparam logic [3:0] S_CK   = 4'd13;
  localparam logic [3:0] S_RD   = 4'd14;

  localparam logic [2:0] CK_NI    = 3'd0;
  localparam logic [2:0] CK_LSEQ  = 3'd1;
  localparam logic [2:0] CK_VALID = 3'd2;
  localparam logic [2:0] CK_PRICE = 3'd3;
  localparam logic [2:0] CK_SEQ   = 3'd4;
  localparam logic [2:0] CK_TS    = 3'd5;
  localparam logic [2:0] CK_DONE  = 3'd6;

  // configuration
  logic [4:0]  exch_cfg_r;
  logic [10:0] instr_cfg_r;
  logic [EW-1:0] e_eff, emax;
  logic [IW-1:0] ni_eff;

  // captured item
  logic [1:0]  op_r;
  logic [15:0] ex_r;
  logic [31:0] ins_r;
  logic [63:0] price_r, seq_r, ts_r;
  logic [2:0]  sel_r;

  // sequencer
  logic [3:0]       state_r, state_nxt;
  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic [IDX_W-1:0] base_r, base_nxt;
  logic [IDX_W-1:0] ck_last_r, ck_last_nxt;
  logic [EW-1:0]    x_r, x_nxt;
  logic [EW-1:0]    k_r, k_nxt;
  logic             have_prev_r, have_prev_nxt;
  logic [KW-1:0]    prev_key_r, prev_key_nxt;
  logic             best_found_r, best_found_nxt;
  logic [KW-1:0]    best_key_r, best_key_nxt;
  logic [63:0]      best_seq_r, best_seq_nxt;
  logic [63:0]      best_ts_r, best_ts_nxt;
  logic [2:0]       step_r, step_nxt;
  logic             dup_r, dup_nxt;
  logic             stale_r, stale_nxt;
  logic [63:0]      gap_r, gap_nxt;
  logic [63:0]      lastseq_r [MAX_EXCHANGES];
  logic [63:0]      lastseq_nxt [MAX_EXCHANGES];
  logic [63:0]      cnt_r [NUM_COUNTERS];
  logic [63:0]      cnt_nxt [NUM_COUNTERS];

  // table memory
  logic [191:0] tbl_mem [TABLE];
  logic         vld_mem [TABLE];
  logic [191:0] rd_data_r;
  logic         rd_vld_r;
  logic         tbl_we, vld_we, vld_wdata;

  // output register
  logic out_valid_r, out_valid_nxt;
  res_t out_r, out_nxt;
  res_t res;
  logic emit, out_free, in_acc;

  fnv_req_t    fnv_req;
  logic        fnv_busy;
  logic [63:0] fnv_hash;

  logic [PW-1:0]    prod_w, cells_w;
  logic [IDX_W-1:0] ap_idx;
  logic [XW-1:0]    ex_idx;
  logic [KW-1:0]    cur_key;
  logic [63:0]      ls_w;
  logic [3:0]       err_st;

  mpt_fnv u_fnv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fnv_req),
    .busy  (fnv_busy),
    .hash  (fnv_hash)
  );

  // effective sizes clamp into the supported range
  always_comb begin
    if (exch_cfg_r == 5'd0) begin
      e_eff = EW'(1);
    end else if (32'(exch_cfg_r) > 32'(MAX_EXCHANGES)) begin
      e_eff = EW'(MAX_EXCHANGES);
    end else begin
      e_eff = EW'(exch_cfg_r);
    end
    if (instr_cfg_r == 11'd0) begin
      ni_eff = IW'(1);
    end else if (32'(instr_cfg_r) > 32'(MAX_INSTRUMENTS)) begin
      ni_eff = IW'(MAX_INSTRUMENTS);
    end else begin
      ni_eff = IW'(instr_cfg_r);
    end
  end

  assign emax     = e_eff - EW'(1);
  assign ex_idx   = ex_r[XW-1:0];
  assign prod_w   = PW'(ins_r[IW-1:0]) * PW'(e_eff);
  assign ap_idx   = IDX_W'(prod_w + PW'(ex_idx));
  assign cells_w  = PW'(ni_eff) * PW'(e_eff) - PW'(1);
  assign cur_key  = {rd_data_r[190:128], x_r};
  assign ls_w     = lastseq_r[ex_idx];
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    if (ex_r >= 16'(e_eff)) begin
      err_st = ST_BAD_EXCH;
    end else if (ins_r >= 32'(ni_eff)) begin
      err_st = ST_BAD_INSTR;
    end else if (price_r == 64'd0 || price_r[63]) begin
      err_st = ST_BAD_PRICE;
    end else if (seq_r == 64'd0) begin
      err_st = ST_BAD_SEQ;
    end else begin
      err_st = ST_OK;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    base_nxt       = base_r;
    ck_last_nxt    = ck_last_r;
    x_nxt          = x_r;
    k_nxt          = k_r;
    have_prev_nxt  = have_prev_r;
    prev_key_nxt   = prev_key_r;
    best_found_nxt = best_found_r;
    best_key_nxt   = best_key_r;
    best_seq_nxt   = best_seq_r;
    best_ts_nxt    = best_ts_r;
    step_nxt       = step_r;
    dup_nxt        = dup_r;
    stale_nxt      = stale_r;
    gap_nxt        = gap_r;
    lastseq_nxt    = lastseq_r;
    cnt_nxt        = cnt_r;
    emit           = 1'b0;
    res            = '0;
    tbl_we         = 1'b0;
    vld_we         = 1'b0;
    vld_wdata      = 1'b0;
    fnv_req        = '0;

    case (state_r)
      S_CLR: begin
        vld_we = 1'b1;
        if (addr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end else begin
          addr_nxt = addr_r + IDX_W'(1);
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          case (in_ch.op)
            OP_APPLY: begin
              cnt_nxt[CNT_RECEIVED] = cnt_r[CNT_RECEIVED] + 64'd1;
              state_nxt = S_A1;
            end
            OP_QUERY:    state_nxt = S_Q0;
            OP_CHECKSUM: state_nxt = S_C0;
            default:     state_nxt = S_RD;
          endcase
        end
      end

      S_A1: begin
        if (err_st != ST_OK) begin
          if (out_free) begin
            emit       = 1'b1;
            res.status = err_st;
            res.last   = 1'b1;
            cnt_nxt[CNT_INVALID] = cnt_r[CNT_INVALID] + 64'd1;
            state_nxt  = S_IDLE;
          end
        end else begin
          addr_nxt  = ap_idx;
          state_nxt = S_A2;
        end
      end

      S_A2: begin
        dup_nxt   = (seq_r == ls_w);
        stale_nxt = (seq_r < ls_w);
        gap_nxt   = seq_r - ls_w - 64'd1;
        state_nxt = S_A3;
      end

      S_A3: begin
        if (out_free) begin
          emit      = 1'b1;
          res.last  = 1'b1;
          state_nxt = S_IDLE;
          if (dup_r) begin
            res.status = ST_DUP;
            cnt_nxt[CNT_DUPLICATE] = cnt_r[CNT_DUPLICATE] + 64'd1;
          end else if (stale_r) begin
            res.status = ST_STALE;
            cnt_nxt[CNT_STALE] = cnt_r[CNT_STALE] + 64'd1;
          end else begin
            tbl_we    = 1'b1;
            vld_we    = 1'b1;
            vld_wdata = 1'b1;
            lastseq_nxt[ex_idx] = seq_r;
            cnt_nxt[CNT_ACCEPTED] = cnt_r[CNT_ACCEPTED] + 64'd1;
            res.status = ST_OK;
            if (gap_r != 64'd0) begin
              res.status    = ST_GAP;
              res.gap_count = gap_r;
              cnt_nxt[CNT_GAP_EVENT] = cnt_r[CNT_GAP_EVENT] + 64'd1;
              cnt_nxt[CNT_MISSING]   = cnt_r[CNT_MISSING] + gap_r;
            end
          end
        end
      end

      S_Q0: begin
        if (ins_r >= 32'(ni_eff)) begin
          if (out_free) begin
            emit       = 1'b1;
            res.status = ST_NO_INSTR;
            res.last   = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else begin
          base_nxt      = IDX_W'(prod_w);
          k_nxt         = '0;
          have_prev_nxt = 1'b0;
          state_nxt     = S_QPS;
        end
      end

      // one pass finds the smallest key above the last row sent
      S_QPS: begin
        addr_nxt       = base_r;
        x_nxt          = '0;
        best_found_nxt = 1'b0;
        state_nxt      = S_QRD;
      end

      S_QRD: state_nxt = S_QCMP;

      S_QCMP: begin
        if (rd_vld_r && (!have_prev_r || cur_key > prev_key_r) &&
            (!best_found_r || cur_key < best_key_r)) begin
          best_found_nxt = 1'b1;
          best_key_nxt   = cur_key;
          best_seq_nxt   = rd_data_r[127:64];
          best_ts_nxt    = rd_data_r[63:0];
        end
        if (x_r == emax) begin
          state_nxt = S_QEND;
        end else begin
          x_nxt     = x_r + EW'(1);
          addr_nxt  = addr_r + IDX_W'(1);
          state_nxt = S_QRD;
        end
      end

      S_QEND: begin
        if (best_found_r) begin
          if (out_free) begin
            emit              = 1'b1;
            res.status        = ST_PRICE_ROW;
            res.exchange_out  = 4'(best_key_r[EW-1:0]);
            res.price_out     = {1'b0, best_key_r[KW-1:EW]};
            res.sequence_out  = best_seq_r;
            res.timestamp_out = best_ts_r;
            res.last          = (k_r == emax);
            prev_key_nxt      = best_key_r;
            have_prev_nxt     = 1'b1;
            k_nxt             = k_r + EW'(1);
            state_nxt         = (k_r == emax) ? S_IDLE : S_QPS;
          end
        end else begin
          addr_nxt  = base_r;
          x_nxt     = '0;
          state_nxt = S_MRD;
        end
      end

      S_MRD: state_nxt = S_MCHK;

      // exchanges without a price, ascending
      S_MCHK: begin
        if (rd_vld_r || out_free) begin
          if (!rd_vld_r) begin
            emit             = 1'b1;
            res.status       = ST_MISSING;
            res.exchange_out = 4'(x_r);
            res.last         = (k_r == emax);
            k_nxt            = k_r + EW'(1);
          end
          if (x_r == emax) begin
            state_nxt = S_IDLE;
          end else begin
            x_nxt     = x_r + EW'(1);
            addr_nxt  = addr_r + IDX_W'(1);
            state_nxt = S_MRD;
          end
        end
      end

      S_C0: begin
        fnv_req.init  = 1'b1;
        fnv_req.start = 1'b1;
        fnv_req.word  = 64'(e_eff);
        ck_last_nxt   = IDX_W'(cells_w);
        step_nxt      = CK_NI;
        state_nxt     = S_CK;
      end

      S_CK: begin
        if (!fnv_busy) begin
          case (step_r)
            CK_NI: begin
              fnv_req.start = 1'b1;
              fnv_req.word  = 64'(ni_eff);
              x_nxt         = '0;
              step_nxt      = CK_LSEQ;
            end
            CK_LSEQ: begin
              fnv_req.start = 1'b1;
              fnv_req.word  = lastseq_r[x_r[XW-1:0]];
              if (x_r == emax) begin
                addr_nxt = '0;
                step_nxt = CK_VALID;
              end else begin
                x_nxt = x_r + EW'(1);
              end
            end
            CK_VALID: begin
              fnv_req.start = 1'b1;
              fnv_req.word  = {63'd0, rd_vld_r};
              if (rd_vld_r) begin
                step_nxt = CK_PRICE;
              end else if (addr_r == ck_last_r) begin
                step_nxt = CK_DONE;
              end else begin
                addr_nxt = addr_r + IDX_W'(1);
              end
            end
            CK_PRICE: begin
              fnv_req.start = 1'b1;
              fnv_req.word  = rd_data_r[191:128];
              step_nxt      = CK_SEQ;
            end
            CK_SEQ: begin
              fnv_req.start = 1'b1;
              fnv_req.word  = rd_data_r[127:64];
              step_nxt      = CK_TS;
            end
            CK_TS: begin
              fnv_req.start = 1'b1;
              fnv_req.word  = rd_data_r[63:0];
              if (addr_r == ck_last_r) begin
                step_nxt = CK_DONE;
              end else begin
                addr_nxt = addr_r + IDX_W'(1);
                step_nxt = CK_VALID;
              end
            end
            default: begin
              if (out_free) begin
                emit          = 1'b1;
                res.status    = ST_VALUE;
                res.value_out = fnv_hash;
                res.last      = 1'b1;
                state_nxt     = S_IDLE;
              end
            end
          endcase
        end
      end

      S_RD: begin
        if (out_free) begin
          emit          = 1'b1;
          res.status    = ST_VALUE;
          res.value_out = (sel_r == CNT_NONE) ? 64'd0 : cnt_r[sel_r];
          res.last      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
      exch_cfg_r  <= 5'd16;
      instr_cfg_r <= 11'd1024;
      for (int i = 0; i < MAX_EXCHANGES; i++) begin
        lastseq_r[i] <= 64'd0;
      end
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        cnt_r[i] <= 64'd0;
      end
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= out_valid_nxt;
      lastseq_r   <= lastseq_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_EXCHANGES:   exch_cfg_r  <= cfg_data[4:0];
          CFG_INSTRUMENTS: instr_cfg_r <= cfg_data;
          default: ;
        endcase
      end
    end
    base_r       <= base_nxt;
    ck_last_r    <= ck_last_nxt;
    x_r          <= x_nxt;
    k_r          <= k_nxt;
    have_prev_r  <= have_prev_nxt;
    prev_key_r   <= prev_key_nxt;
    best_found_r <= best_found_nxt;
    best_key_r   <= best_key_nxt;
    best_seq_r   <= best_seq_nxt;
    best_ts_r    <= best_ts_nxt;
    step_r       <= step_nxt;
    dup_r        <= dup_nxt;
    stale_r      <= stale_nxt;
    gap_r        <= gap_nxt;
    out_r        <= out_nxt;
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= in_ch.op;
      ex_r    <= in_ch.exchange_num;
      ins_r   <= in_ch.instrument_num;
      price_r <= in_ch.price_in;
      seq_r   <= in_ch.sequence_in;
      ts_r    <= in_ch.timestamp_in;
      sel_r   <= in_ch.counter_select;
    end
  end

  // single port table, registered read
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[addr_r] <= {price_r, seq_r, ts_r};
    end
    rd_data_r <= tbl_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (vld_we) begin
      vld_mem[addr_r] <= vld_wdata;
    end
    rd_vld_r <= vld_mem[addr_r];
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_r.status;
  assign out_ch.gap_count     = out_r.gap_count;
  assign out_ch.exchange_out  = out_r.exchange_out;
  assign out_ch.price_out     = out_r.price_out;
  assign out_ch.sequence_out  = out_r.sequence_out;
  assign out_ch.timestamp_out = out_r.timestamp_out;
  assign out_ch.value_out     = out_r.value_out;
  assign out_ch.last          = out_r.last;

  `MPT_ASSERT_IMP(a_emit_room, clk, rst_n, emit, out_free)
  `MPT_ASSERT_IMP(a_fnv_start_idle, clk, rst_n, fnv_req.start, !fnv_busy)
  `MPT_ASSERT_IMP(a_data_write_marks, clk, rst_n, tbl_we, vld_we && vld_wdata)
  `MPT_ASSERT_NXT(a_apply_op, clk, rst_n, state_r == S_IDLE && state_nxt == S_A1,
                  op_r == OP_APPLY)

endmodule

// File: design/mpt_fnv.sv
// ----------------------------------------------------------------------------
// mpt_fnv
// fnv-1a hash unit, folds one 64-bit word in byte by byte, low byte first
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpt_fnv (
  input  logic              clk,
  input  logic              rst_n,
  input  mpt_pkg::fnv_req_t req,
  output logic              busy,
  output logic [63:0]       hash
);
  import mpt_pkg::*;

  logic [63:0] hash_r, hash_nxt;
  logic [63:0] word_r, word_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;

  always_comb begin
    hash_nxt = hash_r;
    word_nxt = word_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (req.init) begin
      hash_nxt = FNV_BASIS;
    end
    if (busy_r) begin
      hash_nxt = fnv_step(hash_r, word_r[7:0]);
      word_nxt = word_r >> 8;
      cnt_nxt  = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
      end
    end else if (req.start) begin
      word_nxt = req.word;
      cnt_nxt  = 3'd0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    hash_r <= hash_nxt;
    word_r <= word_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign busy = busy_r;
  assign hash = hash_r;

endmodule
